FILE: sv/preemptive_priority_scheduler_assert.svh
// Assertion macros used by the scheduler port checker.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define PPS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define PPS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pps_pkg.sv
// Shared widths, operation codes and structs of the priority scheduler.
package pps_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int OP_W       = 2;
    localparam int PID_W      = 16;
    localparam int ARR_W      = 16;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Operation codes of an input word
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register index (taken from paddr[2])
    localparam logic REG_MODE = 1'b0;

    // Table update commands from the control path
    typedef struct packed {
        logic load;
        logic tick;
        logic mode;
    } pps_ctrl_t;

    // Entry chosen for the current tick
    typedef struct packed {
        logic               found;
        logic [PID_W-1:0]   pid;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               last_unit;
    } pps_pick_t;

endpackage

FILE: sv/pps_if.sv
// Valid/ready channels for input words and result words.
interface pps_item_if;
    import pps_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [PID_W-1:0]   process_id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;

    modport source (output valid, op, process_id, arrival, burst, prio, input ready);
    modport sink   (input valid, op, process_id, arrival, burst, prio, output ready);
endinterface

interface pps_result_if;
    import pps_pkg::*;

    logic              valid;
    logic              ready;
    logic              running_valid;
    logic [PID_W-1:0]  running_pid;
    logic              segment_start;
    logic [TIME_W-1:0] tick_time;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;

    modport source (output valid, running_valid, running_pid, segment_start, tick_time,
                    finished, completion_time, turnaround, waiting, all_done,
                    input ready);
    modport sink   (input valid, running_valid, running_pid, segment_start, tick_time,
                    finished, completion_time, turnaround, waiting, all_done,
                    output ready);
endinterface

FILE: sv/pps_cfg.sv
// APB register block holding the priority mode.
module pps_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pps_pkg::DATA_W-1:0]      pwdata,
    output logic [pps_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output logic                            mode
);
    import pps_pkg::*;

    logic mode_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && paddr[2] == REG_MODE;

    // Write the mode bit on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Read back; unmapped addresses return zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MODE)
        begin
            prdata = {{(DATA_W-1){1'b0}}, mode_reg};
        end
    end

    assign mode = mode_reg;

endmodule

FILE: sv/pps_table.sv
// Process table lanes with a parallel best-priority selection tree.
module pps_table #(
    parameter int MAX_PROCS = 16,
    parameter int IDX_W     = $clog2(MAX_PROCS),
    parameter int CNT_W     = $clog2(MAX_PROCS + 1)
) (
    input  logic                          clk,
    input  pps_pkg::pps_ctrl_t            ctrl,
    input  logic [IDX_W-1:0]              load_slot,
    input  logic [pps_pkg::PID_W-1:0]     load_pid,
    input  logic [pps_pkg::ARR_W-1:0]     load_arrival,
    input  logic [pps_pkg::BURST_W-1:0]   load_burst,
    input  logic [pps_pkg::PRIO_W-1:0]    load_prio,
    input  logic [CNT_W-1:0]              count,
    input  logic [pps_pkg::TIME_W-1:0]    now,
    output pps_pkg::pps_pick_t            pick
);
    import pps_pkg::*;

    localparam int LEAVES = 1 << IDX_W;

    logic [PID_W-1:0]   id_reg    [MAX_PROCS];
    logic [ARR_W-1:0]   arr_reg   [MAX_PROCS];
    logic [BURST_W-1:0] burst_reg [MAX_PROCS];
    logic [PRIO_W-1:0]  prio_reg  [MAX_PROCS];
    logic [BURST_W-1:0] rem_reg   [MAX_PROCS];

    // Heap-ordered tree: node k merges nodes 2k and 2k+1, leaves at LEAVES..2*LEAVES-1
    logic              node_ok   [1:2*LEAVES-1];
    logic [PRIO_W-1:0] node_prio [1:2*LEAVES-1];
    logic [IDX_W-1:0]  node_idx  [1:2*LEAVES-1];

    logic [IDX_W-1:0]  sel;

    // Leaves: an entry is eligible once loaded, arrived and not yet done
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < MAX_PROCS)
        begin : g_real
            assign node_ok[LEAVES+i]   = (CNT_W'(i) < count)
                                         && ({{(TIME_W-ARR_W){1'b0}}, arr_reg[i]} <= now)
                                         && (rem_reg[i] != '0);
            assign node_prio[LEAVES+i] = prio_reg[i];
        end
        else
        begin : g_pad
            assign node_ok[LEAVES+i]   = 1'b0;
            assign node_prio[LEAVES+i] = '0;
        end
        assign node_idx[LEAVES+i] = IDX_W'(i);
    end

    // Merge pairs; the left (lower slot) child keeps a tie
    for (genvar k = 1; k < LEAVES; k++)
    begin : g_node
        logic take_right;

        assign take_right   = node_ok[2*k+1]
                              && (!node_ok[2*k]
                                  || (ctrl.mode ? (node_prio[2*k+1] > node_prio[2*k])
                                                : (node_prio[2*k+1] < node_prio[2*k])));
        assign node_ok[k]   = node_ok[2*k] || node_ok[2*k+1];
        assign node_prio[k] = take_right ? node_prio[2*k+1] : node_prio[2*k];
        assign node_idx[k]  = take_right ? node_idx[2*k+1]  : node_idx[2*k];
    end

    assign sel = node_idx[1];

    // Read out the chosen entry
    always_comb
    begin
        pick = '0;
        pick.found = node_ok[1];
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            if (sel == IDX_W'(i))
            begin
                pick.pid       = id_reg[i];
                pick.arrival   = arr_reg[i];
                pick.burst     = burst_reg[i];
                pick.last_unit = rem_reg[i] == BURST_W'(1);
            end
        end
    end

    // Load a slot, or spend one unit of the running entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            if (ctrl.load && load_slot == IDX_W'(i))
            begin
                id_reg[i]    <= load_pid;
                arr_reg[i]   <= load_arrival;
                burst_reg[i] <= load_burst;
                prio_reg[i]  <= load_prio;
                rem_reg[i]   <= load_burst;
            end
            else if (ctrl.tick && node_ok[1] && sel == IDX_W'(i))
            begin
                rem_reg[i] <= rem_reg[i] - BURST_W'(1);
            end
        end
    end

endmodule

FILE: sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: one word per cycle, results registered.
// A tick word is held in the input register, then its result word is written to
// the result register once that register is free, and is taken from there.
// Throughput: one word per cycle while the result side is ready; the pick is a
// combinational parallel tree over MAX_PROCS entries. Loads and clears give no result.
// Reset clears time, counts, last segment and mode; entry stores are not cleared.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pps_pkg::DATA_W-1:0]      pwdata,
    output logic [pps_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    pps_item_if.sink                        item,
    pps_result_if.source                    result
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    logic               mode;
    pps_ctrl_t          ctrl;
    pps_pick_t          pick;

    // Input register
    logic               in_valid_reg;
    logic [OP_W-1:0]    op_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [ARR_W-1:0]   arr_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRIO_W-1:0]  prio_reg;

    // Scheduler state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               last_valid_reg, last_valid_next;
    logic [PID_W-1:0]   last_id_reg, last_id_next;

    // Result register
    logic               out_valid_reg;
    logic               rv_reg;
    logic [PID_W-1:0]   rpid_reg;
    logic               seg_reg;
    logic [TIME_W-1:0]  ttime_reg;
    logic               fin_reg;
    logic [TIME_W-1:0]  ct_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [TIME_W-1:0]  wt_reg;
    logic               alldone_reg;

    logic               is_tick;
    logic               out_free;
    logic               advance;
    logic               load_ok;
    logic [TIME_W-1:0]  time_after;
    logic               fin;
    logic               seg;
    logic [TIME_W-1:0]  tat;
    logic [TIME_W-1:0]  wt;
    logic [TIME_W-1:0]  burst_ext;
    logic [CNT_W-1:0]   done_after;

    pps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    // Handshake: only a tick needs room in the result register
    assign is_tick    = op_reg == OP_TICK;
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && (!is_tick || out_free);
    assign item.ready = !in_valid_reg || advance;
    assign load_ok    = count_reg < CNT_W'(MAX_PROCS);

    assign ctrl.load = advance && op_reg == OP_LOAD && load_ok;
    assign ctrl.tick = advance && is_tick;
    assign ctrl.mode = mode;

    pps_table #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_table (
        .clk          (clk),
        .ctrl         (ctrl),
        .load_slot    (count_reg[IDX_W-1:0]),
        .load_pid     (pid_reg),
        .load_arrival (arr_reg),
        .load_burst   (burst_reg),
        .load_prio    (prio_reg),
        .count        (count_reg),
        .now          (time_reg),
        .pick         (pick)
    );

    // Tick figures
    assign time_after = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + TIME_W'(1);
    assign fin        = pick.found && pick.last_unit;
    assign seg        = pick.found ? (!last_valid_reg || last_id_reg != pick.pid)
                                   : last_valid_reg;
    assign burst_ext  = {{(TIME_W-BURST_W){1'b0}}, pick.burst};
    assign tat        = time_after - {{(TIME_W-ARR_W){1'b0}}, pick.arrival};
    assign wt         = (tat >= burst_ext) ? tat - burst_ext : '0;
    assign done_after = done_reg + CNT_W'(fin);

    // Next state per operation
    always_comb
    begin
        count_next      = count_reg;
        done_next       = done_reg;
        time_next       = time_reg;
        last_valid_next = last_valid_reg;
        last_id_next    = last_id_reg;
        if (advance)
        begin
            unique case (op_reg)
                OP_LOAD:
                begin
                    if (load_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (burst_reg == '0)
                        begin
                            done_next = done_reg + CNT_W'(1);
                        end
                    end
                end
                OP_TICK:
                begin
                    time_next       = time_after;
                    done_next       = done_after;
                    last_valid_next = pick.found;
                    if (pick.found)
                    begin
                        last_id_next = pick.pid;
                    end
                end
                OP_CLEAR:
                begin
                    count_next      = '0;
                    done_next       = '0;
                    time_next       = '0;
                    last_valid_next = 1'b0;
                    last_id_next    = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            done_reg       <= '0;
            time_reg       <= '0;
            last_valid_reg <= 1'b0;
            last_id_reg    <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (ctrl.tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg      <= count_next;
            done_reg       <= done_next;
            time_reg       <= time_next;
            last_valid_reg <= last_valid_next;
            last_id_reg    <= last_id_next;
        end
    end

    // Capture input word and result word payloads
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            op_reg    <= item.op;
            pid_reg   <= item.process_id;
            arr_reg   <= item.arrival;
            burst_reg <= item.burst;
            prio_reg  <= item.prio;
        end
        if (ctrl.tick)
        begin
            rv_reg      <= pick.found;
            rpid_reg    <= pick.found ? pick.pid : '0;
            seg_reg     <= seg;
            ttime_reg   <= time_reg;
            fin_reg     <= fin;
            ct_reg      <= fin ? time_after : '0;
            tat_reg     <= fin ? tat : '0;
            wt_reg      <= fin ? wt : '0;
            alldone_reg <= done_after == count_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.running_valid   = rv_reg;
    assign result.running_pid     = rpid_reg;
    assign result.segment_start   = seg_reg;
    assign result.tick_time       = ttime_reg;
    assign result.finished        = fin_reg;
    assign result.completion_time = ct_reg;
    assign result.turnaround      = tat_reg;
    assign result.waiting         = wt_reg;
    assign result.all_done        = alldone_reg;

endmodule

FILE: sv/pps_checker.sv
// Port-level checks on the scheduler result words, bound to the top level.
module pps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         running_valid,
    input logic [pps_pkg::PID_W-1:0]    running_pid,
    input logic                         segment_start,
    input logic [pps_pkg::TIME_W-1:0]   tick_time,
    input logic                         finished,
    input logic [pps_pkg::TIME_W-1:0]   completion_time,
    input logic [pps_pkg::TIME_W-1:0]   turnaround,
    input logic [pps_pkg::TIME_W-1:0]   waiting,
    input logic                         all_done
);
    import pps_pkg::*;
    `include "preemptive_priority_scheduler_assert.svh"

    // An idle tick names no process and finishes nothing
    `PPS_CHECK_NOW(a_idle_clean, res_valid && !running_valid, running_pid == '0 && !finished, "idle tick carries a process")

    // Completion lands one unit after the tick start, saturating at the top
    `PPS_CHECK_NOW(a_completion_time, res_valid && finished, (tick_time != TIME_MAX && completion_time == tick_time + TIME_W'(1)) || (tick_time == TIME_MAX && completion_time == TIME_MAX), "completion time off the tick")

    // Waiting never exceeds turnaround
    `PPS_CHECK_NOW(a_wait_bound, res_valid && finished, waiting <= turnaround, "waiting exceeds turnaround")

    // A stalled result word holds
    `PPS_CHECK_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable({running_valid, running_pid, segment_start, tick_time, finished, completion_time, turnaround, waiting, all_done}), "stalled result word changed")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .running_valid   (result.running_valid),
    .running_pid     (result.running_pid),
    .segment_start   (result.segment_start),
    .tick_time       (result.tick_time),
    .finished        (result.finished),
    .completion_time (result.completion_time),
    .turnaround      (result.turnaround),
    .waiting         (result.waiting),
    .all_done        (result.all_done)
);

FILE: dv/pps_schedule_checker.sv
// Checker for the priority scheduler: predicts each tick report and compares it.
module pps_schedule_checker #(
    parameter int SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [pps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pps_pkg::DATA_W-1:0]     pwdata,
    pps_item_if                            item,
    pps_result_if                          result,
    output int unsigned                    outstanding,
    output int unsigned                    fault_count
);
    import pps_pkg::*;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] remaining;
    } slot_t;

    typedef struct packed {
        logic              running_valid;
        logic [PID_W-1:0]  running_pid;
        logic              segment_start;
        logic [TIME_W-1:0] tick_time;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } tick_report_t;

    // Scheduler state as seen by the predictor
    slot_t             slots [SLOTS];
    int unsigned       slots_used;
    int unsigned       slots_done;
    logic [TIME_W-1:0] clock_now;
    logic              prev_busy;
    logic [PID_W-1:0]  prev_pid;
    logic              mode_hi;

    tick_report_t      pending_reports [$];
    int unsigned       faults = 0;

    function automatic void clear_table();
        slots_used = 0;
        slots_done = 0;
        clock_now  = '0;
        prev_busy  = 1'b0;
        prev_pid   = '0;
    endfunction

    // Pick the best arrived, unfinished slot, run it for one unit and report
    function automatic tick_report_t schedule_tick();
        tick_report_t      r;
        int                pick;
        logic [TIME_W-1:0] after;
        r    = '0;
        pick = -1;
        for (int i = 0; i < slots_used; i++) begin
            if ({{(TIME_W-ARR_W){1'b0}}, slots[i].arrival} <= clock_now &&
                slots[i].remaining != '0) begin
                if (pick < 0 ||
                    (mode_hi ? slots[i].prio > slots[pick].prio
                             : slots[i].prio < slots[pick].prio))
                    pick = i;
            end
        end
        after       = (clock_now == TIME_MAX) ? TIME_MAX : clock_now + TIME_W'(1);
        r.tick_time = clock_now;
        if (pick < 0) begin
            r.segment_start = prev_busy;
            prev_busy       = 1'b0;
        end
        else begin
            r.running_valid = 1'b1;
            r.running_pid   = slots[pick].pid;
            r.segment_start = !prev_busy || prev_pid != slots[pick].pid;
            prev_busy       = 1'b1;
            prev_pid        = slots[pick].pid;
            slots[pick].remaining = slots[pick].remaining - BURST_W'(1);
            if (slots[pick].remaining == '0) begin
                r.finished        = 1'b1;
                r.completion_time = after;
                r.turnaround      = after - TIME_W'(slots[pick].arrival);
                r.waiting         = (r.turnaround >= TIME_W'(slots[pick].burst)) ?
                                    r.turnaround - TIME_W'(slots[pick].burst) : '0;
                slots_done++;
            end
        end
        clock_now  = after;
        r.all_done = (slots_done == slots_used);
        return r;
    endfunction

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            faults++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        tick_report_t want;
        if (!rst_n) begin
            clear_table();
            mode_hi = 1'b0;
            pending_reports.delete();
        end
        else begin
            // Track the mode register
            if (psel && penable && pwrite && pready && paddr[2] == REG_MODE)
                mode_hi = pwdata[0];

            // Compare a delivered report with the oldest prediction
            if (result.valid && result.ready) begin
                if (pending_reports.size() == 0) begin
                    $error("result word with no tick pending");
                    faults++;
                end
                else begin
                    want = pending_reports.pop_front();
                    check_field("running_valid", TIME_W'(want.running_valid),
                                TIME_W'(result.running_valid));
                    check_field("running_pid", TIME_W'(want.running_pid),
                                TIME_W'(result.running_pid));
                    check_field("segment_start", TIME_W'(want.segment_start),
                                TIME_W'(result.segment_start));
                    check_field("tick_time", want.tick_time, result.tick_time);
                    check_field("finished", TIME_W'(want.finished),
                                TIME_W'(result.finished));
                    check_field("completion_time", want.completion_time,
                                result.completion_time);
                    check_field("turnaround", want.turnaround, result.turnaround);
                    check_field("waiting", want.waiting, result.waiting);
                    check_field("all_done", TIME_W'(want.all_done),
                                TIME_W'(result.all_done));
                end
            end

            // Apply an accepted input word
            if (item.valid && item.ready) begin
                case (item.op)
                    OP_LOAD:
                        if (slots_used < SLOTS) begin
                            slots[slots_used] = '{item.process_id, item.arrival,
                                                  item.burst, item.prio, item.burst};
                            slots_used++;
                            if (item.burst == '0)
                                slots_done++;
                        end
                    OP_TICK:  pending_reports.push_back(schedule_tick());
                    OP_CLEAR: clear_table();
                    default:  ;
                endcase
            end
        end
        outstanding <= pending_reports.size();
        fault_count <= faults;
    end

endmodule

FILE: dv/tb.sv
// Testbench top: drives words and mode writes into the scheduler and gives the verdict.
module tb;
    import pps_pkg::*;

    localparam int TABLE_DEPTH = 16;

    localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
    localparam logic            MODE_LOW_WINS  = 1'b0;
    localparam logic            MODE_HIGH_WINS = 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    int unsigned outstanding;
    int unsigned fault_count;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned words_sent     = 0;

    pps_item_if   item_ch ();
    pps_result_if result_ch ();

    preemptive_priority_scheduler #(
        .MAX_PROCS (TABLE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    pps_schedule_checker #(
        .SLOTS (TABLE_DEPTH)
    ) u_sched_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .item        (item_ch),
        .result      (result_ch),
        .outstanding (outstanding),
        .fault_count (fault_count)
    );

    always #4 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold off the sender at random, then present one word until it is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                             input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] len,
                             input logic [PRIO_W-1:0] pri);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.process_id <= pid;
        item_ch.arrival    <= arr;
        item_ch.burst      <= len;
        item_ch.prio       <= pri;
        do @(posedge clk); while (!item_ch.ready);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // Send a word whose entry fields are ignored
    task automatic send_noise(input logic [OP_W-1:0] op);
        send_word(op, PID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
                  PRIO_W'($urandom));
    endtask

    // Drop valid and wait until every tick report has come back
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_priority_mode(input logic mode);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= {{(DATA_W-1){1'b0}}, mode};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Clear and load random entries, then send ticks mixed with stray other words
    task automatic run_batch();
        int unsigned      count;
        int unsigned      work;
        int unsigned      latest;
        int unsigned      ticks;
        int unsigned      pick;
        logic [PID_W-1:0]   pid;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] len;
        logic [PRIO_W-1:0]  pri;
        send_noise(OP_CLEAR);
        count  = ($urandom_range(7) == 0) ? $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 4)
                                          : $urandom_range(1, TABLE_DEPTH);
        work   = 0;
        latest = 0;
        for (int i = 0; i < count; i++)
        begin
            pid = PID_W'(($urandom_range(2) == 0) ? $urandom_range(3) : $urandom);
            arr = ARR_W'(($urandom_range(29) == 0) ? $urandom : $urandom_range(12));
            pick = $urandom_range(39);
            if (pick < 4)
                len = '0;
            else if (pick == 4)
                len = BURST_W'($urandom);
            else
                len = BURST_W'($urandom_range(1, 6));
            pri = PRIO_W'(($urandom_range(1) == 0) ? $urandom_range(3) : $urandom);
            if ($urandom_range(19) == 0)
                send_noise(OP_UNUSED);
            send_word(OP_LOAD, pid, arr, len, pri);
            if (len <= BURST_W'(6))
                work += 32'(len);
            if (arr <= ARR_W'(12) && 32'(arr) > latest)
                latest = 32'(arr);
        end
        ticks = work + latest + $urandom_range(4);
        if (ticks > 90)
            ticks = 90;
        for (int t = 0; t < ticks; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_noise(OP_CLEAR);
            else if (pick < 5)
                send_noise(OP_UNUSED);
            else if (pick < 7)
                send_word(OP_LOAD, PID_W'($urandom), ARR_W'($urandom_range(12)),
                          BURST_W'($urandom_range(1, 4)), PRIO_W'($urandom));
            else
                send_noise(OP_TICK);
        end
    endtask

    initial
    begin
        int unsigned round_end;
        rst_n              = 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.op        <= OP_LOAD;
        item_ch.process_id <= '0;
        item_ch.arrival   <= '0;
        item_ch.burst     <= '0;
        item_ch.prio      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Idle tick on an empty table opens no segment; unknown op is ignored
        set_priority_mode(MODE_LOW_WINS);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_UNUSED, '1, '1, '1, '1);
        // Tie on the lowest slot, same id back to back, zero burst, late arrival
        send_word(OP_LOAD, 16'hFFFF, 16'd0, 16'd2, 8'hFF);
        send_word(OP_LOAD, 16'h0000, 16'd0, 16'd1, 8'h00);
        send_word(OP_LOAD, 16'h0000, 16'd1, 16'd1, 8'h00);
        send_word(OP_LOAD, 16'h0007, 16'd0, 16'd0, 8'h00);
        send_word(OP_LOAD, 16'h0009, 16'd7, 16'd1, 8'h01);
        repeat (8) send_word(OP_TICK, '1, '1, '1, '1);
        send_word(OP_CLEAR, '1, '1, '1, '1);
        // An entry that never arrives keeps the table busy but idle
        send_word(OP_LOAD, 16'h0001, 16'hFFFF, 16'hFFFF, 8'h80);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_CLEAR, '0, '0, '0, '0);
        // Higher number wins
        set_priority_mode(MODE_HIGH_WINS);
        send_word(OP_LOAD, 16'h0002, 16'd0, 16'd1, 8'd1);
        send_word(OP_LOAD, 16'h0003, 16'd0, 16'd1, 8'd200);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_TICK, '0, '0, '0, '0);

        // Random batches across idle phases and both modes
        for (int blk = 0; blk < 8; blk++)
        begin
            set_priority_mode((blk >= 4) ? MODE_HIGH_WINS : MODE_LOW_WINS);
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            round_end = words_sent + 100;
            while (words_sent < round_end)
                run_batch();
        end

        settle();
        if (fault_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
